// File: sv/pvwma_pkg.sv
// Shared types and constants for the per-view window metric averager.
`default_nettype none
package pvwma_pkg;
	localparam int NUM_VIEWS_DEF    = 16;
	localparam int WINDOW_DEPTH_DEF = 120;
	localparam int VIEW_W  = 4;
	localparam int WF_W    = 8;
	localparam int FU_W    = 7;
	localparam int TIME_W  = 32;
	localparam int RATE_W  = 16;
	localparam int RATIO_W = 16;

	typedef enum logic {
		REQ_RECORD = 1'b0,
		REQ_QUERY  = 1'b1
	} req_t;

	// Command passed from the front end to the back end through the queue.
	typedef struct packed {
		req_t              req;
		logic              view_ok;
		logic [VIEW_W-1:0] view;
		logic [TIME_W-1:0] time_v;
		logic [TIME_W-1:0] p95;
		logic [TIME_W-1:0] p99;
		logic [4*RATE_W-1:0] rates;
		logic [WF_W-1:0]   frames;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_ACC,
		ST_DIV,
		ST_OUT
	} state_t;
endpackage
`default_nettype wire

// File: sv/per_view_window_metric_averager.sv
// A query walks the samples it uses, if any, then runs the serial division, raises out_valid
// and holds the back end until the result is taken; a record writes its sample and is done.
// One item is worked on at a time.
// A two-entry queue accepts items while the back end works.
// Reset: arst_n clears pointers, counts and control; the sample memory needs no clearing.
`default_nettype none
module per_view_window_metric_averager import pvwma_pkg::*; #(
	parameter int NUM_VIEWS    = NUM_VIEWS_DEF,
	parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire logic req_type,
	input  wire logic [VIEW_W-1:0] view_id,
	input  wire logic [TIME_W-1:0] sample_time,
	input  wire logic [TIME_W-1:0] sample_p95,
	input  wire logic [TIME_W-1:0] sample_p99,
	input  wire logic [RATE_W-1:0] sample_warp_eff,
	input  wire logic [RATE_W-1:0] sample_branch_div,
	input  wire logic [RATE_W-1:0] sample_coalesce,
	input  wire logic [RATE_W-1:0] sample_l2_miss,
	input  wire logic [WF_W-1:0]   frames_req,
	output logic      out_valid,
	input  wire logic out_stall,
	output logic [TIME_W-1:0] mean_time,
	output logic [RATE_W-1:0] mean_warp_eff,
	output logic [RATE_W-1:0] mean_branch_div,
	output logic [RATE_W-1:0] mean_coalesce,
	output logic [RATE_W-1:0] mean_l2_miss,
	output logic [TIME_W-1:0] tail_p95,
	output logic [TIME_W-1:0] tail_p99,
	output logic [RATIO_W-1:0] p99_p95_ratio,
	output logic [FU_W-1:0]   frames_used
);
	logic cmd_valid, cmd_pop;
	cmd_t cmd;

	pvwma_front #(.NUM_VIEWS(NUM_VIEWS)) u_front (.*);
	pvwma_back #(.NUM_VIEWS(NUM_VIEWS), .WINDOW_DEPTH(WINDOW_DEPTH)) u_back (.*);

`ifndef SYNTH
	a_pop_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid) else $error("pop from empty queue");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(mean_time) && $stable(frames_used))
		else $error("result changed under stall");
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !cmd_pop) else $error("pop while result pending");
`endif
endmodule
`default_nettype wire

// File: sv/pvwma_front.sv
// Front end: accepts transactions, classifies them and queues commands.
`default_nettype none
module pvwma_front import pvwma_pkg::*; #(
	parameter int NUM_VIEWS = NUM_VIEWS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire logic req_type,
	input  wire logic [VIEW_W-1:0] view_id,
	input  wire logic [TIME_W-1:0] sample_time,
	input  wire logic [TIME_W-1:0] sample_p95,
	input  wire logic [TIME_W-1:0] sample_p99,
	input  wire logic [RATE_W-1:0] sample_warp_eff,
	input  wire logic [RATE_W-1:0] sample_branch_div,
	input  wire logic [RATE_W-1:0] sample_coalesce,
	input  wire logic [RATE_W-1:0] sample_l2_miss,
	input  wire logic [WF_W-1:0]   frames_req,
	output logic cmd_valid,
	output cmd_t cmd,
	input  wire logic cmd_pop
);
	// two-entry queue
	cmd_t       buf_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push;
	cmd_t       nc;

	assign in_stall  = (cnt_q == 2'd2);
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = buf_q[rp_q];

	// classify the incoming transaction
	always_comb begin
		nc.req     = req_t'(req_type);
		nc.view_ok = ({24'd0, view_id} < 28'(NUM_VIEWS));
		nc.view    = view_id;
		nc.time_v  = sample_time;
		nc.p95     = sample_p95;
		nc.p99     = sample_p99;
		nc.rates   = {sample_l2_miss, sample_coalesce, sample_branch_div, sample_warp_eff};
		nc.frames  = frames_req;
	end

	// write the payload
	always_ff @(posedge clk) begin
		if (push) buf_q[wp_q] <= nc;
	end

	// advance the pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (cmd_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop);
		end
	end
endmodule
`default_nettype wire

// File: sv/pvwma_div.sv
// Restoring divider: one quotient bit per cycle.
`default_nettype none
module pvwma_div #(
	parameter int NW = 48,
	parameter int DW = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic busy,
	output logic [NW-1:0] quo
);
	localparam int CW = $clog2(NW + 1);
	logic [NW-1:0] quo_q;
	logic [DW:0]   rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic [DW:0]   sh;
	logic          ge;

	assign sh   = {rem_q[DW-1:0], quo_q[NW-1]};
	assign ge   = (sh >= {1'b0, den_q});
	assign busy = (cnt_q != '0);
	assign quo  = quo_q;

	// shift in one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(NW);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num; rem_q <= '0; den_q <= den;
		end else if (busy) begin
			rem_q <= ge ? (sh - {1'b0, den_q}) : sh;
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end
endmodule
`default_nettype wire

// File: sv/pvwma_back.sv
// Back end: sample memory, window walk, dividers and result fields.
`default_nettype none
module pvwma_back import pvwma_pkg::*; #(
	parameter int NUM_VIEWS    = NUM_VIEWS_DEF,
	parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	input  cmd_t      cmd,
	output logic      cmd_pop,
	output logic      out_valid,
	input  wire logic out_stall,
	output logic [TIME_W-1:0] mean_time,
	output logic [RATE_W-1:0] mean_warp_eff,
	output logic [RATE_W-1:0] mean_branch_div,
	output logic [RATE_W-1:0] mean_coalesce,
	output logic [RATE_W-1:0] mean_l2_miss,
	output logic [TIME_W-1:0] tail_p95,
	output logic [TIME_W-1:0] tail_p99,
	output logic [RATIO_W-1:0] p99_p95_ratio,
	output logic [FU_W-1:0]   frames_used
);
	localparam int DEPTH = NUM_VIEWS * WINDOW_DEPTH;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CNTW  = $clog2(WINDOW_DEPTH + 1);
	localparam int VW    = (NUM_VIEWS > 1) ? $clog2(NUM_VIEWS) : 1;
	localparam int TSW   = TIME_W + CNTW;
	localparam int RSW   = RATE_W + CNTW;
	localparam int MW    = 3 * TIME_W + 4 * RATE_W;

	// sample memory, one word per slot
	logic [MW-1:0] mem [DEPTH];
	logic [MW-1:0] rd_q;

	logic [SW-1:0]   newest_q [NUM_VIEWS];
	logic [CNTW-1:0] count_q  [NUM_VIEWS];

	state_t state_q, state_d;
	cmd_t   c_q;
	logic [CNTW-1:0] n_q, k_q;
	logic [SW-1:0]   slot_q;
	logic [AW-1:0]   base_q;
	logic [TSW-1:0]  sum_t_q;
	logic [RSW-1:0]  sum_r_q [4];
	logic [TIME_W-1:0] p95_q, p99_q;
	logic            divgo;
	logic [5:0]      dbusy;
	logic [TSW-1:0]  qt;
	logic [RSW-1:0]  qr [4];
	logic [TIME_W+8-1:0] qratio;
	logic [VW-1:0]   vi;
	logic [CNTW-1:0] nsel;
	logic [SW-1:0]   nslot;

	assign vi = c_q.view[VW-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (cmd_valid) state_d = ST_READ;
			ST_READ: begin
				if (c_q.req == REQ_RECORD || !c_q.view_ok || nsel == '0) state_d = ST_DIV;
				else state_d = ST_ACC;
			end
			ST_ACC:  if (k_q == n_q) state_d = ST_DIV;
			ST_DIV: begin
				if (c_q.req == REQ_RECORD) state_d = ST_IDLE;
				else if (!divgo && dbusy == '0) state_d = ST_OUT;
			end
			ST_OUT:  if (!out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		cmd_pop   = (state_q == ST_IDLE) && cmd_valid;
		out_valid = (state_q == ST_OUT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// count of samples to use and the next slot for a record
	always_comb begin
		if ({{(32-WF_W){1'b0}}, c_q.frames} < 32'(count_q[vi])) nsel = CNTW'(c_q.frames);
		else nsel = count_q[vi];
		nslot = (32'(newest_q[vi]) == WINDOW_DEPTH - 1) ? '0 : newest_q[vi] + 1'b1;
	end

	// per-view pointers and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_VIEWS; i++) begin
				newest_q[i] <= '0; count_q[i] <= '0;
			end
		end else if (state_q == ST_READ && c_q.req == REQ_RECORD && c_q.view_ok) begin
			newest_q[vi] <= nslot;
			if (32'(count_q[vi]) < WINDOW_DEPTH) count_q[vi] <= count_q[vi] + 1'b1;
		end
	end

	// memory write and read
	always_ff @(posedge clk) begin
		if (state_q == ST_READ && c_q.req == REQ_RECORD && c_q.view_ok)
			mem[AW'(32'(vi) * WINDOW_DEPTH) + AW'(nslot)] <= {c_q.rates, c_q.p99, c_q.p95, c_q.time_v};
		rd_q <= mem[base_q + AW'(slot_q)];
	end

	// walk the window, newest first; read data is registered, so it lags the address
	always_ff @(posedge clk) begin
		divgo <= 1'b0;
		unique case (state_q)
			ST_IDLE: c_q <= cmd;
			ST_READ: begin
				n_q <= nsel;
				k_q <= '0;
				slot_q <= newest_q[vi];
				base_q <= AW'(32'(vi) * WINDOW_DEPTH);
				sum_t_q <= '0;
				for (int j = 0; j < 4; j++) sum_r_q[j] <= '0;
				p95_q <= '0; p99_q <= '0;
				if (!(c_q.req == REQ_RECORD || !c_q.view_ok || nsel == '0)) begin
					slot_q <= newest_q[vi];
				end
				if (c_q.req == REQ_QUERY && (!c_q.view_ok || nsel == '0)) n_q <= '0;
				if (c_q.req == REQ_QUERY) divgo <= 1'b1;
				if (!c_q.view_ok) n_q <= '0;
			end
			ST_ACC: begin
				if (k_q != '0) begin
					sum_t_q <= sum_t_q + TSW'(rd_q[TIME_W-1:0]);
					p95_q <= rd_q[2*TIME_W-1:TIME_W];
					p99_q <= rd_q[3*TIME_W-1:2*TIME_W];
					for (int j = 0; j < 4; j++)
						sum_r_q[j] <= sum_r_q[j] + RSW'(rd_q[3*TIME_W+RATE_W*j +: RATE_W]);
				end
				k_q <= k_q + 1'b1;
				slot_q <= (slot_q == '0) ? SW'(WINDOW_DEPTH - 1) : slot_q - 1'b1;
				if (k_q == n_q) divgo <= 1'b1;
			end
			default: ;
		endcase
	end

	// dividers; a zero count yields all ones, masked below
	pvwma_div #(.NW(TSW), .DW(CNTW)) u_dt (.clk, .arst_n, .start(divgo),
		.num(sum_t_q), .den(n_q), .busy(dbusy[0]), .quo(qt));
	for (genvar j = 0; j < 4; j++) begin : g_rd
		pvwma_div #(.NW(RSW), .DW(CNTW)) u_dr (.clk, .arst_n, .start(divgo),
			.num(sum_r_q[j]), .den(n_q), .busy(dbusy[1+j]), .quo(qr[j]));
	end
	pvwma_div #(.NW(TIME_W+8), .DW(TIME_W)) u_dq (.clk, .arst_n, .start(divgo),
		.num({p99_q, 8'd0}), .den(p95_q), .busy(dbusy[5]), .quo(qratio));

	// result fields
	always_comb begin
		logic z;
		z = (n_q == '0);
		mean_time       = z ? '0 : qt[TIME_W-1:0];
		mean_warp_eff   = z ? '0 : qr[0][RATE_W-1:0];
		mean_branch_div = z ? '0 : qr[1][RATE_W-1:0];
		mean_coalesce   = z ? '0 : qr[2][RATE_W-1:0];
		mean_l2_miss    = z ? '0 : qr[3][RATE_W-1:0];
		tail_p95        = p95_q;
		tail_p99        = p99_q;
		if (z || p95_q == '0) p99_p95_ratio = '0;
		else if (qratio[TIME_W+8-1:RATIO_W] != '0) p99_p95_ratio = '1;
		else p99_p95_ratio = qratio[RATIO_W-1:0];
		frames_used     = FU_W'(32'(n_q));
	end
endmodule
`default_nettype wire

// File: bench/pvwma_checker.sv
// Checker for the per-view window metric averager: window model, expected-result queue, compare.
`default_nettype none
module pvwma_checker import pvwma_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic in_stall,
	input  wire logic req_type,
	input  wire logic [VIEW_W-1:0] view_id,
	input  wire logic [TIME_W-1:0] sample_time,
	input  wire logic [TIME_W-1:0] sample_p95,
	input  wire logic [TIME_W-1:0] sample_p99,
	input  wire logic [RATE_W-1:0] sample_warp_eff,
	input  wire logic [RATE_W-1:0] sample_branch_div,
	input  wire logic [RATE_W-1:0] sample_coalesce,
	input  wire logic [RATE_W-1:0] sample_l2_miss,
	input  wire logic [WF_W-1:0]   frames_req,
	input  wire logic out_valid,
	input  wire logic out_stall,
	input  wire logic [TIME_W-1:0] mean_time,
	input  wire logic [RATE_W-1:0] mean_warp_eff,
	input  wire logic [RATE_W-1:0] mean_branch_div,
	input  wire logic [RATE_W-1:0] mean_coalesce,
	input  wire logic [RATE_W-1:0] mean_l2_miss,
	input  wire logic [TIME_W-1:0] tail_p95,
	input  wire logic [TIME_W-1:0] tail_p99,
	input  wire logic [RATIO_W-1:0] p99_p95_ratio,
	input  wire logic [FU_W-1:0]   frames_used,
	output int        fail_count,
	output int        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = WINDOW_DEPTH_DEF;
	localparam int QN    = 16;

	typedef struct packed {
		logic [TIME_W-1:0]  m_time;
		logic [RATE_W-1:0]  m_warp;
		logic [RATE_W-1:0]  m_branch;
		logic [RATE_W-1:0]  m_coal;
		logic [RATE_W-1:0]  m_l2;
		logic [TIME_W-1:0]  p95;
		logic [TIME_W-1:0]  p99;
		logic [RATIO_W-1:0] ratio;
		logic [FU_W-1:0]    used;
	} summary_t;

	logic [TIME_W-1:0]   win_time [NUM_VIEWS_DEF][DEPTH];
	logic [TIME_W-1:0]   win_p95  [NUM_VIEWS_DEF][DEPTH];
	logic [TIME_W-1:0]   win_p99  [NUM_VIEWS_DEF][DEPTH];
	logic [4*RATE_W-1:0] win_rate [NUM_VIEWS_DEF][DEPTH];
	int                  head  [NUM_VIEWS_DEF];
	int                  count [NUM_VIEWS_DEF];
	summary_t            exp_ring [QN];
	int                  wr_idx, rd_idx, exp_cnt;

	assign pending = exp_cnt;

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	// Build the expected summary over the newest frames of one view
	function automatic summary_t window_summary(input int v, input int frames);
		summary_t s;
		logic [63:0] sum_t;
		logic [63:0] sum_r [4];
		logic [63:0] q;
		int n;
		int slot;
		s = '0;
		sum_t = 0;
		for (int j = 0; j < 4; j++) sum_r[j] = 0;
		n = (frames < count[v]) ? frames : count[v];
		if (v >= NUM_VIEWS_DEF || n == 0) return s;
		for (int k = 0; k < n; k++) begin
			slot = (head[v] + DEPTH - k) % DEPTH;
			sum_t = sum_t + 64'(win_time[v][slot]);
			for (int j = 0; j < 4; j++)
				sum_r[j] = sum_r[j] + 64'(win_rate[v][slot][16*j +: 16]);
			s.p95 = win_p95[v][slot];
			s.p99 = win_p99[v][slot];
		end
		q = sum_t / 64'(n);
		s.m_time = q[TIME_W-1:0];
		q = sum_r[0] / 64'(n);
		s.m_warp = q[RATE_W-1:0];
		q = sum_r[1] / 64'(n);
		s.m_branch = q[RATE_W-1:0];
		q = sum_r[2] / 64'(n);
		s.m_coal = q[RATE_W-1:0];
		q = sum_r[3] / 64'(n);
		s.m_l2 = q[RATE_W-1:0];
		if (s.p95 != 0) begin
			q = {24'd0, s.p99, 8'd0} / {32'd0, s.p95};
			s.ratio = (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
		end
		s.used = n[FU_W-1:0];
		return s;
	endfunction

	// Track accepted transactions and check results
	always @(posedge clk or negedge arst_n) begin
		summary_t s;
		int v;
		if (!arst_n) begin
			fail_count = 0;
			wr_idx = 0;
			rd_idx = 0;
			exp_cnt = 0;
			for (int i = 0; i < NUM_VIEWS_DEF; i++) begin
				head[i] = 0;
				count[i] = 0;
			end
		end else begin
			if (out_valid && !out_stall) begin
				if (exp_cnt == 0) begin
					report("unexpected result", 0, 0);
				end else begin
					s = exp_ring[rd_idx];
					rd_idx = (rd_idx + 1) % QN;
					exp_cnt--;
					if (mean_time != s.m_time) report("mean_time", mean_time, s.m_time);
					if (mean_warp_eff != s.m_warp)
						report("mean_warp_eff", mean_warp_eff, s.m_warp);
					if (mean_branch_div != s.m_branch)
						report("mean_branch_div", mean_branch_div, s.m_branch);
					if (mean_coalesce != s.m_coal)
						report("mean_coalesce", mean_coalesce, s.m_coal);
					if (mean_l2_miss != s.m_l2) report("mean_l2_miss", mean_l2_miss, s.m_l2);
					if (tail_p95 != s.p95) report("tail_p95", tail_p95, s.p95);
					if (tail_p99 != s.p99) report("tail_p99", tail_p99, s.p99);
					if (p99_p95_ratio != s.ratio)
						report("p99_p95_ratio", p99_p95_ratio, s.ratio);
					if (frames_used != s.used) report("frames_used", frames_used, s.used);
				end
			end
			if (in_valid && !in_stall) begin
				v = view_id;
				if (req_type == REQ_RECORD) begin
					head[v] = (head[v] + 1) % DEPTH;
					win_time[v][head[v]] = sample_time;
					win_p95[v][head[v]]  = sample_p95;
					win_p99[v][head[v]]  = sample_p99;
					win_rate[v][head[v]] = {sample_l2_miss, sample_coalesce,
						sample_branch_div, sample_warp_eff};
					if (count[v] < DEPTH) count[v]++;
				end else if (exp_cnt == QN) begin
					report("expected-result overflow", 0, 0);
				end else begin
					exp_ring[wr_idx] = window_summary(v, frames_req);
					wr_idx = (wr_idx + 1) % QN;
					exp_cnt++;
				end
			end
		end
	end
endmodule
`default_nettype wire

// File: bench/tb_per_view_window_metric_averager.sv
// Stimulus and verdict for the per-view window metric averager.
`default_nettype none
module tb_per_view_window_metric_averager import pvwma_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 2_000_000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic out_stall = 1'b0;
	logic in_stall, out_valid;
	logic req_type = 1'b0;
	logic [VIEW_W-1:0] view_id = '0;
	logic [TIME_W-1:0] sample_time = '0, sample_p95 = '0, sample_p99 = '0;
	logic [RATE_W-1:0] sample_warp_eff = '0, sample_branch_div = '0;
	logic [RATE_W-1:0] sample_coalesce = '0, sample_l2_miss = '0;
	logic [WF_W-1:0]   frames_req = '0;
	logic [TIME_W-1:0] mean_time, tail_p95, tail_p99;
	logic [RATE_W-1:0] mean_warp_eff, mean_branch_div, mean_coalesce, mean_l2_miss;
	logic [RATIO_W-1:0] p99_p95_ratio;
	logic [FU_W-1:0]   frames_used;
	int fail_count, pending;
	int cycles = 0;
	bit calm = 1'b0;

	per_view_window_metric_averager dut (.*);
	pvwma_checker chk (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Abort on a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Stall the result side at random, except in the calm stretch
	always @(negedge clk) out_stall <= !calm && ($urandom_range(99) < 25);

	function automatic logic [31:0] edge_word();
		case ($urandom_range(3))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// Present one transaction and hold it until accepted
	task automatic send(input req_t r, input int v, input logic [31:0] t, input logic [31:0] p95,
			input logic [31:0] p99, input logic [63:0] rates, input int frames);
		while (!calm && $urandom_range(99) < 25) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		req_type <= r;
		view_id <= VIEW_W'(v);
		sample_time <= t;
		sample_p95 <= p95;
		sample_p99 <= p99;
		{sample_l2_miss, sample_coalesce, sample_branch_div, sample_warp_eff} <= rates;
		frames_req <= WF_W'(frames);
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic record_random(input int v);
		send(REQ_RECORD, v, edge_word(), edge_word(), edge_word(),
			{edge_word(), edge_word()}, $urandom);
	endtask

	task automatic query_random(input int v);
		int f;
		case ($urandom_range(4))
			0: f = 0;
			1: f = 255;
			2: f = $urandom_range(1, 8);
			default: f = $urandom_range(255);
		endcase
		send(REQ_QUERY, v, $urandom, $urandom, $urandom, {$urandom, $urandom}, f);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty queries, extremes, zero p95, ratio overflow
		send(REQ_QUERY, 0, 0, 0, 0, 0, 10);
		send(REQ_QUERY, 15, 0, 0, 0, 0, 0);
		send(REQ_RECORD, 0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, '1, 0);
		send(REQ_QUERY, 0, 0, 0, 0, 0, 1);
		send(REQ_QUERY, 0, 0, 0, 0, 0, 0);
		send(REQ_RECORD, 0, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, '1, 255);
		send(REQ_RECORD, 0, 0, 32'd100, 32'd150, '0, 0);
		send(REQ_QUERY, 0, 0, 0, 0, 0, 255);
		send(REQ_QUERY, 0, 0, 0, 0, 0, 2);
		send(REQ_QUERY, 0, 0, 0, 0, 0, 1);
		send(REQ_RECORD, 15, 32'h1234_5678, 32'hFFFF_FFFF, 32'd0, 64'h0123_4567_89AB_CDEF, 0);
		send(REQ_QUERY, 15, 0, 0, 0, 0, 255);
		// Fill view 7 past the ring size so it wraps
		for (int i = 0; i < 130; i++) record_random(7);
		send(REQ_QUERY, 7, 0, 0, 0, 0, 255);
		send(REQ_QUERY, 7, 0, 0, 0, 0, 120);
		send(REQ_QUERY, 7, 0, 0, 0, 0, 119);

		// Random mix, mostly records, with a calm stretch in the middle
		for (int i = 0; i < 1800; i++) begin
			calm = (i >= 600 && i < 800);
			if ($urandom_range(99) < 70) record_random($urandom_range(15));
			else query_random($urandom_range(15));
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end
endmodule
`default_nettype wire
